/* rtl/core/hvt_pkg.sv */
// Shared types and constants of the homogeneous vertex transform core.
// Used by hvt_persp_div and homogeneous_vertex_transform_core; depends on nothing.
`default_nettype none

package hvt_pkg;

  localparam int DATA_W    = 32;  // width of one fixed-point component
  localparam int DIM       = 4;   // matrix and vector dimension
  localparam int NUM_LANES = 3;   // x, y and z go through the perspective divide
  localparam int W_ROW     = 3;   // row whose result is the homogeneous w
  localparam int NUM_REGS  = 8;   // two 64-bit registers per matrix row
  localparam int REG_W     = 64;
  localparam int CFG_IDX_W = 4;   // wide enough to address past the last register

  localparam logic [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [1:0] {
    CMD_FULL  = 2'd0,
    CMD_POINT = 2'd1,
    CMD_PERSP = 2'd2,
    CMD_DIR   = 2'd3
  } cmd_t;

  // Rounded and saturated matrix-vector product of one item, plus its flags.
  typedef struct packed {
    cmd_t                         cmd;
    logic [DIM-1:0][DATA_W-1:0]   res;
    logic                         ovf;
    logic                         fault;
  } hvt_side_t;

  // Perspective quotients of x, y and z with their saturation flags.
  typedef struct packed {
    logic [NUM_LANES-1:0][DATA_W-1:0] q;
    logic [NUM_LANES-1:0]             ovf;
  } hvt_quot_t;

  // One finished result transaction.
  typedef struct packed {
    logic [DIM-1:0][DATA_W-1:0] vec;
    logic                       ovf;
    logic                       fault;
  } hvt_result_t;

endpackage

`default_nettype wire

/* rtl/core/homogeneous_vertex_transform_core.sv */
// Top level of the homogeneous vertex transform core: 4x4 fixed-point matrix
// times vector with saturation and perspective divide. Uses hvt_pkg and hvt_persp_div.
`default_nettype none

// Each input transaction carries a command and a vector in signed fixed point
// with FRAC_BITS fraction bits; the core multiplies it by the 4x4 matrix held
// in eight 64-bit configuration registers (identity after reset) and returns
// one result transaction; the default format is Q16.16. The core is fully
// pipelined: while the output buffer has room it takes one transaction per
// clock and delivers one result per clock. Most of its depth lies in the
// perspective divider, which resolves one quotient bit per stage over
// 32 + FRAC_BITS stages; every command goes through it so results leave in
// order. A two-entry output buffer keeps the pipeline running while a result
// waits to be taken, and back pressure stops the whole pipeline only once
// that buffer is full. Each row product is summed exactly, rounded to
// nearest with ties toward positive infinity and saturated to 32 bits; any
// clamp of a result that is used sets the overflow flag. A perspective point
// with a resulting w of zero sets divide_fault and drives x, y and z to the
// limit matching the sign of their numerator, or to zero where it is zero.
// Configuration writes are taken every cycle and must only be issued while no
// transaction is in flight; writes to an index past the last register are
// ignored.

module homogeneous_vertex_transform_core #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Input vector stream.
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [4*hvt_pkg::DATA_W-1:0]      in_tdata,  // vec_x, vec_y, vec_z, vec_w
  input  wire logic [1:0]                        in_tuser,  // command
  // Result stream.
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [4*hvt_pkg::DATA_W-1:0]           out_tdata, // out_x, out_y, out_z, out_w
  output logic [1:0]                             out_tuser, // overflow, divide_fault
  // Matrix register writes.
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [hvt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [hvt_pkg::REG_W-1:0]         cfg_data
);

  localparam int DW     = hvt_pkg::DATA_W;
  localparam int DIM    = hvt_pkg::DIM;
  localparam int NREG   = hvt_pkg::NUM_REGS;
  localparam int RIDX_W = $clog2(NREG);
  localparam int PROD_W = 2 * DW;
  localparam int PAIR_W = PROD_W + 1;
  localparam int SUM_W  = PROD_W + 2;
  localparam int RND_W  = SUM_W - FRAC_BITS;
  localparam int FIFO_DEPTH = 2;

  localparam logic [hvt_pkg::REG_W-1:0] ONE_LO = 64'd1 << FRAC_BITS;
  localparam logic [hvt_pkg::REG_W-1:0] ONE_HI = 64'd1 << (FRAC_BITS + DW);
  localparam logic [hvt_pkg::REG_W-1:0] MAT_RESET [NREG] =
    '{ONE_LO, '0, ONE_HI, '0, '0, ONE_LO, '0, ONE_HI};
  localparam logic [DW-1:0]    FX_ONE = 32'd1 << FRAC_BITS;
  localparam logic [SUM_W-1:0] HALF   = {{(SUM_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

  // Matrix registers. Register 2r holds columns 0 and 1 of row r, register
  // 2r+1 columns 2 and 3, the even column in the low half, so the packed
  // array doubles as a row-major table of 32-bit entries.
  logic [NREG-1:0][hvt_pkg::REG_W-1:0] mat_r;
  logic [DIM-1:0][DIM-1:0][DW-1:0]     ent;

  assign ent       = mat_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NREG; i++) begin
        mat_r[i] <= MAT_RESET[i];
      end
    end else if (cfg_valid && (cfg_index < hvt_pkg::CFG_IDX_W'(NREG))) begin
      mat_r[cfg_index[RIDX_W-1:0]] <= cfg_data;
    end
  end

  // The whole pipeline advances together while the output buffer has room.
  logic                      en;
  logic [1:0]                fifo_cnt_r;

  assign en        = (fifo_cnt_r != 2'(FIFO_DEPTH));
  assign in_tready = en;

  // Stage 0: registered input, with w chosen by the command.
  logic                        s0_vld_r;
  hvt_pkg::cmd_t               s0_cmd_r;
  logic [DIM-1:0][DW-1:0]      s0_vec_r;
  logic [DIM-1:0][DW-1:0]      s0_vec_nxt;
  hvt_pkg::cmd_t               in_cmd;

  assign in_cmd = hvt_pkg::cmd_t'(in_tuser);

  always_comb begin
    s0_vec_nxt = in_tdata;
    case (in_cmd)
      hvt_pkg::CMD_FULL: s0_vec_nxt[hvt_pkg::W_ROW] = in_tdata[hvt_pkg::W_ROW*DW +: DW];
      hvt_pkg::CMD_DIR:  s0_vec_nxt[hvt_pkg::W_ROW] = '0;
      default:           s0_vec_nxt[hvt_pkg::W_ROW] = FX_ONE;
    endcase
  end

  // Stage 1: sixteen 32x32 products.
  logic                                  s1_vld_r;
  hvt_pkg::cmd_t                         s1_cmd_r;
  logic [DIM-1:0][DIM-1:0][PROD_W-1:0]   s1_prod_r;
  logic [DIM-1:0][DIM-1:0][PROD_W-1:0]   s1_prod_nxt;

  always_comb begin
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < DIM; c++) begin
        s1_prod_nxt[r][c] = $signed(ent[r][c]) * $signed(s0_vec_r[c]);
      end
    end
  end

  // Stage 2: pairwise sums of the products of each row.
  logic                                  s2_vld_r;
  hvt_pkg::cmd_t                         s2_cmd_r;
  logic [DIM-1:0][1:0][PAIR_W-1:0]       s2_pair_r;
  logic [DIM-1:0][1:0][PAIR_W-1:0]       s2_pair_nxt;

  always_comb begin
    for (int r = 0; r < DIM; r++) begin
      for (int h = 0; h < 2; h++) begin
        s2_pair_nxt[r][h] = {s1_prod_r[r][2*h][PROD_W-1], s1_prod_r[r][2*h]}
                          + {s1_prod_r[r][2*h+1][PROD_W-1], s1_prod_r[r][2*h+1]};
      end
    end
  end

  // Stage 3: exact row sum, rounded to nearest with ties upward.
  logic                                  s3_vld_r;
  hvt_pkg::cmd_t                         s3_cmd_r;
  logic [DIM-1:0][RND_W-1:0]             s3_rnd_r;
  logic [DIM-1:0][RND_W-1:0]             s3_rnd_nxt;

  always_comb begin
    logic [SUM_W-1:0] sum;
    for (int r = 0; r < DIM; r++) begin
      sum = {s2_pair_r[r][0][PAIR_W-1], s2_pair_r[r][0]}
          + {s2_pair_r[r][1][PAIR_W-1], s2_pair_r[r][1]} + HALF;
      s3_rnd_nxt[r] = sum[SUM_W-1:FRAC_BITS];
    end
  end

  // Stage 4: saturation to 32 bits and the per-command flags.
  logic                  s4_vld_r;
  hvt_pkg::hvt_side_t    s4_side_r;
  hvt_pkg::hvt_side_t    s4_side_nxt;

  always_comb begin
    logic [DIM-1:0][DW-1:0] sat;
    logic [DIM-1:0]         clamp;
    logic                   use_w;
    for (int r = 0; r < DIM; r++) begin
      sat[r]   = s3_rnd_r[r][DW-1:0];
      clamp[r] = 1'b0;
      if (s3_rnd_r[r][RND_W-1] && !(&s3_rnd_r[r][RND_W-2:DW-1])) begin
        sat[r]   = hvt_pkg::Q_MIN;
        clamp[r] = 1'b1;
      end else if (!s3_rnd_r[r][RND_W-1] && (|s3_rnd_r[r][RND_W-2:DW-1])) begin
        sat[r]   = hvt_pkg::Q_MAX;
        clamp[r] = 1'b1;
      end
    end
    // Row 3 counts only where its result is used: as out_w or as the divisor.
    use_w = (s3_cmd_r == hvt_pkg::CMD_FULL) || (s3_cmd_r == hvt_pkg::CMD_PERSP);
    s4_side_nxt.cmd = s3_cmd_r;
    s4_side_nxt.res = sat;
    if (!use_w) begin
      s4_side_nxt.res[hvt_pkg::W_ROW] = '0;
    end
    s4_side_nxt.ovf   = (|clamp[hvt_pkg::W_ROW-1:0]) || (use_w && clamp[hvt_pkg::W_ROW]);
    s4_side_nxt.fault = (s3_cmd_r == hvt_pkg::CMD_PERSP) && (sat[hvt_pkg::W_ROW] == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_tvalid;
      s1_vld_r <= s0_vld_r;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_cmd_r  <= in_cmd;
      s0_vec_r  <= s0_vec_nxt;
      s1_cmd_r  <= s0_cmd_r;
      s1_prod_r <= s1_prod_nxt;
      s2_cmd_r  <= s1_cmd_r;
      s2_pair_r <= s2_pair_nxt;
      s3_cmd_r  <= s2_cmd_r;
      s3_rnd_r  <= s3_rnd_nxt;
      s4_side_r <= s4_side_nxt;
    end
  end

  // Perspective divide; other commands ride along unchanged.
  logic                  div_vld;
  hvt_pkg::hvt_side_t    div_side;
  hvt_pkg::hvt_quot_t    div_quot;

  hvt_persp_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s4_vld_r),
    .in_side   (s4_side_r),
    .out_valid (div_vld),
    .out_side  (div_side),
    .out_quot  (div_quot)
  );

  hvt_pkg::hvt_result_t  res_nxt;

  always_comb begin
    res_nxt.vec   = div_side.res;
    res_nxt.ovf   = div_side.ovf;
    res_nxt.fault = 1'b0;
    if (div_side.cmd == hvt_pkg::CMD_PERSP) begin
      for (int l = 0; l < hvt_pkg::NUM_LANES; l++) begin
        res_nxt.vec[l] = div_quot.q[l];
      end
      res_nxt.vec[hvt_pkg::W_ROW] = '0;
      res_nxt.ovf   = div_side.ovf || (|div_quot.ovf);
      res_nxt.fault = div_side.fault;
    end
  end

  // Output buffer. A result leaves the divider exactly on an enabled edge,
  // and the pipeline only runs while a slot is free, so nothing is dropped.
  hvt_pkg::hvt_result_t  buf_r [FIFO_DEPTH];
  logic                  wr_ptr_r;
  logic                  rd_ptr_r;
  logic                  push;
  logic                  pop;

  assign push = en && div_vld;
  assign pop  = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fifo_cnt_r <= '0;
      wr_ptr_r   <= 1'b0;
      rd_ptr_r   <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        fifo_cnt_r <= fifo_cnt_r + 2'd1;
      end else if (pop && !push) begin
        fifo_cnt_r <= fifo_cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= res_nxt;
    end
  end

  hvt_pkg::hvt_result_t  head;

  assign head       = buf_r[rd_ptr_r];
  assign out_tvalid = (fifo_cnt_r != '0);
  assign out_tdata  = head.vec;
  assign out_tuser  = {head.fault, head.ovf};

endmodule

`default_nettype wire

/* rtl/core/hvt_persp_div.sv */
// Pipelined perspective divider: (t << FRAC_BITS) / w for x, y and z, one
// quotient bit per stage, truncated toward zero and saturated. Uses hvt_pkg.
`default_nettype none

module hvt_persp_div #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire hvt_pkg::hvt_side_t in_side,
  output logic                   out_valid,
  output hvt_pkg::hvt_side_t     out_side,
  output hvt_pkg::hvt_quot_t     out_quot
);

  localparam int DW    = hvt_pkg::DATA_W;
  localparam int LANES = hvt_pkg::NUM_LANES;
  localparam int NUM_W = DW + FRAC_BITS;
  localparam int STEPS = NUM_W;

  // Stage 0 holds the operand magnitudes, stage k+1 the state after quotient step k.
  logic                           vld_r    [STEPS+1];
  logic                           vld_nxt  [STEPS+1];
  hvt_pkg::hvt_side_t             side_r   [STEPS+1];
  hvt_pkg::hvt_side_t             side_nxt [STEPS+1];
  logic [DW-1:0]                  dmag_r   [STEPS+1];
  logic [DW-1:0]                  dmag_nxt [STEPS+1];
  logic [LANES-1:0][NUM_W-1:0]    numq_r   [STEPS+1];
  logic [LANES-1:0][NUM_W-1:0]    numq_nxt [STEPS+1];
  logic [LANES-1:0][DW-1:0]       rem_r    [STEPS+1];
  logic [LANES-1:0][DW-1:0]       rem_nxt  [STEPS+1];

  logic                           out_valid_r;
  hvt_pkg::hvt_side_t             out_side_r;
  hvt_pkg::hvt_quot_t             out_quot_r;
  hvt_pkg::hvt_quot_t             out_quot_nxt;

  always_comb begin
    logic [DW-1:0] t;
    logic [DW-1:0] w;
    logic [DW:0]   sh;
    logic          ge;
    // Operand preparation: magnitudes of the numerators and of w.
    vld_nxt[0]  = in_valid;
    side_nxt[0] = in_side;
    w           = in_side.res[hvt_pkg::W_ROW];
    dmag_nxt[0] = w[DW-1] ? (~w + 1'b1) : w;
    for (int l = 0; l < LANES; l++) begin
      t              = in_side.res[l];
      numq_nxt[0][l] = {(t[DW-1] ? (~t + 1'b1) : t), {FRAC_BITS{1'b0}}};
      rem_nxt[0][l]  = '0;
    end
    // Restoring division, one quotient bit per stage. The dividend drains out
    // of the top of numq while the quotient fills in from the bottom.
    for (int k = 0; k < STEPS; k++) begin
      vld_nxt[k+1]  = vld_r[k];
      side_nxt[k+1] = side_r[k];
      dmag_nxt[k+1] = dmag_r[k];
      for (int l = 0; l < LANES; l++) begin
        sh = {rem_r[k][l], numq_r[k][l][NUM_W-1]};
        ge = (sh >= {1'b0, dmag_r[k]});
        rem_nxt[k+1][l]  = ge ? DW'(sh - {1'b0, dmag_r[k]}) : sh[DW-1:0];
        numq_nxt[k+1][l] = {numq_r[k][l][NUM_W-2:0], ge};
      end
    end
  end

  // Sign, saturation and the zero-divisor case.
  always_comb begin
    logic [DW-1:0]    t;
    logic [DW-1:0]    w;
    logic [NUM_W-1:0] q;
    logic             neg;
    w = side_r[STEPS].res[hvt_pkg::W_ROW];
    for (int l = 0; l < LANES; l++) begin
      t   = side_r[STEPS].res[l];
      q   = numq_r[STEPS][l];
      neg = t[DW-1] ^ w[DW-1];
      out_quot_nxt.q[l]   = q[DW-1:0];
      out_quot_nxt.ovf[l] = 1'b0;
      if (dmag_r[STEPS] == '0) begin
        if (t[DW-1]) begin
          out_quot_nxt.q[l]   = hvt_pkg::Q_MIN;
          out_quot_nxt.ovf[l] = 1'b1;
        end else if (|t) begin
          out_quot_nxt.q[l]   = hvt_pkg::Q_MAX;
          out_quot_nxt.ovf[l] = 1'b1;
        end else begin
          out_quot_nxt.q[l]   = '0;
        end
      end else if (neg) begin
        if ((|q[NUM_W-1:DW]) || (q[DW-1] && (|q[DW-2:0]))) begin
          out_quot_nxt.q[l]   = hvt_pkg::Q_MIN;
          out_quot_nxt.ovf[l] = 1'b1;
        end else begin
          out_quot_nxt.q[l]   = ~q[DW-1:0] + 1'b1;
        end
      end else if (|q[NUM_W-1:DW-1]) begin
        out_quot_nxt.q[l]   = hvt_pkg::Q_MAX;
        out_quot_nxt.ovf[l] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= STEPS; k++) begin
        vld_r[k] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (en) begin
      for (int k = 0; k <= STEPS; k++) begin
        vld_r[k] <= vld_nxt[k];
      end
      out_valid_r <= vld_r[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= STEPS; k++) begin
        side_r[k] <= side_nxt[k];
        dmag_r[k] <= dmag_nxt[k];
        numq_r[k] <= numq_nxt[k];
        rem_r[k]  <= rem_nxt[k];
      end
      out_side_r <= side_r[STEPS];
      out_quot_r <= out_quot_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_side  = out_side_r;
  assign out_quot  = out_quot_r;

endmodule

`default_nettype wire
